// ===== rtl/core/hte_pkg.sv =====
// Shared types and constants for the homogeneous transform engine.
// No dependencies; every other file of the block refers to it by scoped names.
package hte_pkg;

    localparam int FRAC_BITS  = 16;
    localparam int DATA_WIDTH = 32;
    localparam int PORT_W     = 32;
    localparam int MAT_DIM    = 4;
    localparam int MAT_SIZE   = MAT_DIM * MAT_DIM;
    localparam int IDX_W      = $clog2(MAT_SIZE);
    localparam int PROD_W     = DATA_WIDTH + PORT_W;
    localparam int PAIR_W     = PROD_W + 1;
    localparam int SUM_W      = PROD_W + 2;
    localparam int QDEPTH     = 4;
    localparam int QAW        = $clog2(QDEPTH);
    localparam int QCW        = $clog2(QDEPTH + 1);

    localparam logic [DATA_WIDTH-1:0] ONE = DATA_WIDTH'(64'd1 << FRAC_BITS);

    localparam logic [2:0] CMD_IDENT = 3'd0;
    localparam logic [2:0] CMD_SCALE = 3'd1;
    localparam logic [2:0] CMD_TRANS = 3'd2;
    localparam logic [2:0] CMD_WRITE = 3'd3;
    localparam logic [2:0] CMD_READ  = 3'd4;
    localparam logic [2:0] CMD_XFORM = 3'd5;

    typedef enum logic [2:0] {
        OP_NOP,
        OP_IDENT,
        OP_SCALE,
        OP_TRANS,
        OP_WRITE,
        OP_READ,
        OP_XFORM
    } t_op_kind;

    typedef struct packed {
        logic        [2:0]  cmd;
        logic        [2:0]  row;
        logic        [2:0]  col;
        logic signed [31:0] value;
        logic signed [31:0] x;
        logic signed [31:0] y;
        logic signed [31:0] z;
        logic signed [31:0] w;
    } t_item;

    typedef struct packed {
        logic signed [31:0] out_x;
        logic signed [31:0] out_y;
        logic signed [31:0] out_z;
        logic signed [31:0] out_w;
        logic signed [31:0] read_value;
    } t_result;

    typedef struct packed {
        t_op_kind                 kind;
        logic [IDX_W-1:0]         idx;
        logic [DATA_WIDTH-1:0]    value;
        logic signed [PORT_W-1:0] x;
        logic signed [PORT_W-1:0] y;
        logic signed [PORT_W-1:0] z;
        logic signed [PORT_W-1:0] w;
    } t_op;

endpackage

// ===== rtl/core/hte_front.sv =====
// Front end: accepts input transactions, decodes them into operations
// and buffers them in a short queue. Depends on hte_pkg.
module hte_front (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_valid,
    output logic          o_stall,
    input  hte_pkg::t_item i_item,
    output logic          o_op_valid,
    input  logic          i_op_pop,
    output hte_pkg::t_op  o_op
);

    hte_pkg::t_op               n_op;
    hte_pkg::t_op               r_mem [hte_pkg::QDEPTH];
    logic [hte_pkg::QAW-1:0]    r_wr_ptr;
    logic [hte_pkg::QAW-1:0]    r_rd_ptr;
    logic [hte_pkg::QCW-1:0]    r_count;
    logic                       w_push;
    logic                       w_in_range;

    assign o_stall    = (r_count == hte_pkg::QCW'(hte_pkg::QDEPTH));
    assign o_op_valid = (r_count != '0);
    assign o_op       = r_mem[r_rd_ptr];
    assign w_push     = i_valid && !o_stall;

    assign w_in_range = (i_item.row < 3'(hte_pkg::MAT_DIM)) &&
                        (i_item.col < 3'(hte_pkg::MAT_DIM));

    always_comb begin
        n_op.idx   = hte_pkg::IDX_W'(int'(i_item.row) * hte_pkg::MAT_DIM + int'(i_item.col));
        n_op.value = i_item.value[hte_pkg::DATA_WIDTH-1:0];
        n_op.x     = i_item.x;
        n_op.y     = i_item.y;
        n_op.z     = i_item.z;
        n_op.w     = i_item.w;
        case (i_item.cmd)
            hte_pkg::CMD_IDENT: n_op.kind = hte_pkg::OP_IDENT;
            hte_pkg::CMD_SCALE: n_op.kind = hte_pkg::OP_SCALE;
            hte_pkg::CMD_TRANS: n_op.kind = hte_pkg::OP_TRANS;
            // drop out-of-range element accesses: a read then returns zero
            hte_pkg::CMD_WRITE: n_op.kind = w_in_range ? hte_pkg::OP_WRITE : hte_pkg::OP_NOP;
            hte_pkg::CMD_READ:  n_op.kind = w_in_range ? hte_pkg::OP_READ : hte_pkg::OP_NOP;
            hte_pkg::CMD_XFORM: n_op.kind = hte_pkg::OP_XFORM;
            default:            n_op.kind = hte_pkg::OP_NOP;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (w_push) begin
            r_mem[r_wr_ptr] <= n_op;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (w_push) begin
                r_wr_ptr <= r_wr_ptr + 1'b1;
            end
            if (i_op_pop) begin
                r_rd_ptr <= r_rd_ptr + 1'b1;
            end
            case ({w_push, i_op_pop})
                2'b10:   r_count <= r_count + 1'b1;
                2'b01:   r_count <= r_count - 1'b1;
                default: r_count <= r_count;
            endcase
        end
    end

endmodule

// ===== rtl/core/hte_back.sv =====
// Back end: holds the coefficient matrix, applies operations in order and
// runs transforms through multiply, pair-add and sum/saturate stages. Uses hte_pkg.
module hte_back (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_op_valid,
    output logic            o_op_pop,
    input  hte_pkg::t_op    i_op,
    output logic            o_valid,
    input  logic            i_stall,
    output hte_pkg::t_result o_result
);

    logic [hte_pkg::DATA_WIDTH-1:0]    r_coef [hte_pkg::MAT_SIZE];
    logic [hte_pkg::DATA_WIDTH-1:0]    n_coef [hte_pkg::MAT_SIZE];
    logic signed [hte_pkg::PORT_W-1:0] w_vec  [hte_pkg::MAT_DIM];
    logic signed [hte_pkg::PROD_W-1:0] n_prod [hte_pkg::MAT_SIZE];
    logic signed [hte_pkg::PROD_W-1:0] r_prod [hte_pkg::MAT_SIZE];
    logic signed [hte_pkg::PAIR_W-1:0] n_pair [2*hte_pkg::MAT_DIM];
    logic signed [hte_pkg::PAIR_W-1:0] r_pair [2*hte_pkg::MAT_DIM];
    logic signed [hte_pkg::SUM_W-1:0]  w_sum  [hte_pkg::MAT_DIM];
    logic [hte_pkg::DATA_WIDTH-1:0]    w_sat  [hte_pkg::MAT_DIM];
    logic                              w_adv;
    logic                              r_s1_valid;
    logic                              r_s1_xform;
    logic [hte_pkg::DATA_WIDTH-1:0]    r_s1_read;
    logic                              r_s2_valid;
    logic                              r_s2_xform;
    logic [hte_pkg::DATA_WIDTH-1:0]    r_s2_read;
    logic                              r_out_valid;
    hte_pkg::t_result                  r_result;
    hte_pkg::t_result                  n_result;

    function automatic logic [hte_pkg::DATA_WIDTH-1:0] f_sat(
        input logic signed [hte_pkg::SUM_W-1:0] v
    );
        logic signed [hte_pkg::SUM_W-1:0]            sh;
        logic [hte_pkg::SUM_W-hte_pkg::DATA_WIDTH:0] upper;
        sh    = v >>> hte_pkg::FRAC_BITS;
        upper = sh[hte_pkg::SUM_W-1:hte_pkg::DATA_WIDTH-1];
        if ((&upper) || !(|upper)) begin
            f_sat = sh[hte_pkg::DATA_WIDTH-1:0];
        end else if (upper[hte_pkg::SUM_W-hte_pkg::DATA_WIDTH]) begin
            f_sat = {1'b1, {(hte_pkg::DATA_WIDTH-1){1'b0}}};
        end else begin
            f_sat = {1'b0, {(hte_pkg::DATA_WIDTH-1){1'b1}}};
        end
    endfunction

    // hold the whole pipeline while a finished result waits to be taken
    assign w_adv    = !(r_out_valid && i_stall);
    assign o_op_pop = w_adv && i_op_valid;
    assign o_valid  = r_out_valid;
    assign o_result = r_result;

    assign w_vec[0] = i_op.x;
    assign w_vec[1] = i_op.y;
    assign w_vec[2] = i_op.z;
    assign w_vec[3] = i_op.w;

    always_comb begin
        for (int i = 0; i < hte_pkg::MAT_SIZE; i++) begin
            n_coef[i] = r_coef[i];
        end
        if (o_op_pop) begin
            case (i_op.kind)
                hte_pkg::OP_IDENT, hte_pkg::OP_SCALE, hte_pkg::OP_TRANS: begin
                    for (int r = 0; r < hte_pkg::MAT_DIM; r++) begin
                        for (int c = 0; c < hte_pkg::MAT_DIM; c++) begin
                            n_coef[r*hte_pkg::MAT_DIM+c] = (r == c) ? hte_pkg::ONE : '0;
                        end
                    end
                    for (int k = 0; k < hte_pkg::MAT_DIM - 1; k++) begin
                        if (i_op.kind == hte_pkg::OP_SCALE) begin
                            n_coef[k*hte_pkg::MAT_DIM+k] =
                                w_vec[k][hte_pkg::DATA_WIDTH-1:0];
                        end else if (i_op.kind == hte_pkg::OP_TRANS) begin
                            n_coef[k*hte_pkg::MAT_DIM+hte_pkg::MAT_DIM-1] =
                                w_vec[k][hte_pkg::DATA_WIDTH-1:0];
                        end
                    end
                end
                hte_pkg::OP_WRITE: n_coef[i_op.idx] = i_op.value;
                default: ;
            endcase
        end
    end

    always_comb begin
        for (int r = 0; r < hte_pkg::MAT_DIM; r++) begin
            for (int c = 0; c < hte_pkg::MAT_DIM; c++) begin
                n_prod[r*hte_pkg::MAT_DIM+c] =
                    $signed(r_coef[r*hte_pkg::MAT_DIM+c]) * w_vec[c];
            end
        end
        for (int r = 0; r < hte_pkg::MAT_DIM; r++) begin
            for (int h = 0; h < 2; h++) begin
                n_pair[r*2+h] = hte_pkg::PAIR_W'(r_prod[r*hte_pkg::MAT_DIM+2*h]) +
                                hte_pkg::PAIR_W'(r_prod[r*hte_pkg::MAT_DIM+2*h+1]);
            end
        end
        for (int r = 0; r < hte_pkg::MAT_DIM; r++) begin
            w_sum[r] = hte_pkg::SUM_W'(r_pair[2*r]) + hte_pkg::SUM_W'(r_pair[2*r+1]);
            w_sat[r] = f_sat(w_sum[r]);
        end
        n_result.out_x      = r_s2_xform ? 32'($signed(w_sat[0])) : '0;
        n_result.out_y      = r_s2_xform ? 32'($signed(w_sat[1])) : '0;
        n_result.out_z      = r_s2_xform ? 32'($signed(w_sat[2])) : '0;
        n_result.out_w      = r_s2_xform ? 32'($signed(w_sat[3])) : '0;
        n_result.read_value = 32'($signed(r_s2_read));
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < hte_pkg::MAT_SIZE; i++) begin
                r_coef[i] <= '0;
            end
            r_s1_valid  <= 1'b0;
            r_s2_valid  <= 1'b0;
            r_out_valid <= 1'b0;
        end else if (w_adv) begin
            for (int i = 0; i < hte_pkg::MAT_SIZE; i++) begin
                r_coef[i] <= n_coef[i];
            end
            r_s1_valid  <= i_op_valid;
            r_s2_valid  <= r_s1_valid;
            r_out_valid <= r_s2_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            for (int i = 0; i < hte_pkg::MAT_SIZE; i++) begin
                r_prod[i] <= n_prod[i];
            end
            r_s1_xform <= (i_op.kind == hte_pkg::OP_XFORM);
            r_s1_read  <= (i_op.kind == hte_pkg::OP_READ) ? r_coef[i_op.idx] : '0;
            for (int i = 0; i < 2*hte_pkg::MAT_DIM; i++) begin
                r_pair[i] <= n_pair[i];
            end
            r_s2_xform <= r_s1_xform;
            r_s2_read  <= r_s1_read;
            r_result   <= n_result;
        end
    end

endmodule

// ===== rtl/core/homogeneous_transform_engine_top.sv =====
// Homogeneous 4x4 transform engine, top level. Uses hte_pkg, hte_front, hte_back.
// A transaction passes the queue slot, product stage, pair-add stage and
// sum/saturate output register. Throughput: one transaction per cycle while the
// output is not stalled, set by the 16 parallel multipliers.
// Reset (synchronous, active low) clears the matrix to zero and empties the queue.
module homogeneous_transform_engine_top (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_valid,
    output logic             o_stall,
    input  hte_pkg::t_item   i_item,
    output logic             o_valid,
    input  logic             i_stall,
    output hte_pkg::t_result o_result
);

    logic         w_op_valid;
    logic         w_op_pop;
    hte_pkg::t_op w_op;

    hte_front u_front (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_valid    (i_valid),
        .o_stall    (o_stall),
        .i_item     (i_item),
        .o_op_valid (w_op_valid),
        .i_op_pop   (w_op_pop),
        .o_op       (w_op)
    );

    hte_back u_back (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_op_valid (w_op_valid),
        .o_op_pop   (w_op_pop),
        .i_op       (w_op),
        .o_valid    (o_valid),
        .i_stall    (i_stall),
        .o_result   (o_result)
    );

`ifndef SYNTH
    a_pop_needs_op: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_op_pop |-> w_op_valid)
        else $error("queue popped while empty");

    a_read_excludes_vector: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_result.read_value != 0) |->
            (o_result.out_x == 0 && o_result.out_y == 0 &&
             o_result.out_z == 0 && o_result.out_w == 0))
        else $error("element read carries vector data");

    a_full_after_push: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(o_stall) |-> $past(i_valid && !o_stall))
        else $error("queue filled without a push");
`endif

endmodule
